// ===== hdl/jhp_pkg.sv =====
// Package for the jitter histogram percentile block: constants, codes and word types.
// Used by every module in hdl/.
package jhp_pkg;

  localparam int HIST_BINS        = 600;
  localparam int BIN_WIDTH        = 10;
  localparam int MAX_WINDOW       = 1024;
  localparam int MAX_SHORT_WINDOW = 64;

  localparam int BIN_W   = $clog2(HIST_BINS);
  localparam int LPTR_W  = $clog2(MAX_WINDOW);
  localparam int SPTR_W  = $clog2(MAX_SHORT_WINDOW);
  localparam int FILL_W  = 11;
  localparam int SFILL_W = 7;
  localparam int CNT_W   = 16;

  localparam logic [12:0] LOW_FILL_VALUE = 13'd240;
  localparam logic [15:0] CNT_MAX        = 16'hFFFF;

  localparam logic [2:0] ACT_SNAP  = 3'd0;
  localparam logic [2:0] ACT_SKIP  = 3'd1;
  localparam logic [2:0] ACT_EMPTY = 3'd2;
  localparam logic [2:0] ACT_QUERY = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [0:0] REG_WINDOW_LEN     = 1'd0;
  localparam logic [0:0] REG_AVG_WINDOW_LEN = 1'd1;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] duration_ms;
    logic [15:0] pending_min_ms;
  } in_word_t;

  typedef struct packed {
    logic [12:0] dev_a;
    logic [12:0] dev_b;
    logic [12:0] max_dur;
    logic [12:0] min_dur;
    logic [15:0] window_min_pending;
    logic [21:0] skip_total;
    logic [21:0] empty_total;
  } out_word_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic [2:0]       action;
    logic [BIN_W-1:0] bin;
    logic [15:0]      pending;
  } cmd_t;

endpackage

// ===== hdl/jhp_front.sv =====
// Front end: takes input words, bins the duration and drops unused codes.
// Depends on jhp_pkg.
module jhp_front import jhp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic [15:0] quot;
  logic [BIN_W-1:0] bin_sat;

  // Duration by ten through a reciprocal multiply: (x*52429)>>19 is exact for 16 bits.
  logic [31:0] prod;
  assign prod = 32'(in_word.duration_ms) * 32'd52429;
  assign quot = 16'(prod[31:19]);

  always_comb begin
    if (quot >= 16'(HIST_BINS)) begin
      bin_sat = BIN_W'(HIST_BINS - 1);
    end else begin
      bin_sat = quot[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_push <= 1'b0;
    end else begin
      q_push <= in_valid && !q_full && (in_word.action <= ACT_CLEAR);
    end
    q_cmd.action  <= in_word.action;
    q_cmd.bin     <= bin_sat;
    q_cmd.pending <= in_word.pending_min_ms;
  end

endmodule

// ===== hdl/jhp_queue.sv =====
// Short command queue between the front and back ends.
// Depends on jhp_pkg.
module jhp_queue import jhp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic not_empty,
  output logic nearly_full,
  output cmd_t head
);

  localparam int DEPTH = 4;
  cmd_t slots [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign not_empty   = (count != 3'd0);
  assign nearly_full = (count >= 3'd2);
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hdl/jhp_back.sv =====
// Back end: histogram and rings in memories, a sequencer that snaps, counts,
// clears and walks the bins for queries. Depends on jhp_pkg.
module jhp_back import jhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [10:0] window_len,
  input  logic [6:0]  avg_window_len,
  input  logic        cfg_clear,
  input  logic        q_valid,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        done,
  output logic        result_strobe,
  output out_word_t   result
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SNAP_RD, S_SNAP_OLD, S_SNAP_DEC, S_SNAP_INC, S_SNAP_WR,
    S_EVT, S_EVT_WR, S_Q_HIST, S_Q_RING, S_Q_DONE
  } state_t;

  state_t state;

  logic [BIN_W-1:0]  bin_ring  [MAX_WINDOW];
  logic [CNT_W-1:0]  histogram [HIST_BINS];
  logic [15:0]       pend_ring [MAX_SHORT_WINDOW];
  logic [CNT_W-1:0]  skip_ring [MAX_SHORT_WINDOW];
  logic [CNT_W-1:0]  empty_ring[MAX_SHORT_WINDOW];

  logic [LPTR_W-1:0] long_pointer;
  logic [SPTR_W-1:0] short_pointer;
  logic [FILL_W-1:0] fill_count;
  logic [SFILL_W-1:0] short_fill;

  logic [FILL_W-1:0]  eff_long;
  logic [SFILL_W-1:0] eff_short;
  logic [FILL_W-1:0]  lim;
  logic [20:0]        lim_prod;

  cmd_t cmd;
  logic [LPTR_W:0]    sweep;
  logic [BIN_W-1:0]   old_bin;
  logic [CNT_W-1:0]   hist_rd;
  logic [BIN_W-1:0]   hist_addr;
  logic [BIN_W:0]     walk;
  logic               walk_rd;
  logic [BIN_W-1:0]   walk_bin;
  logic [26:0]        cum;
  logic               a_found, seen, b_found;
  logic [BIN_W-1:0]   a_bin, b_bin;
  logic [SPTR_W:0]    ridx;
  logic               ring_rd;
  logic [SPTR_W-1:0]  ring_slot;
  logic [15:0]        pend_rd;
  logic [CNT_W-1:0]   skip_rd, empty_rd;
  logic [15:0]        gmin;
  logic [21:0]        skips, empties;
  logic [SPTR_W-1:0]  evt_slot;
  logic [CNT_W-1:0]   evt_rd;

  always_comb begin
    if (window_len == '0) begin
      eff_long = FILL_W'(1);
    end else if (window_len > FILL_W'(MAX_WINDOW)) begin
      eff_long = FILL_W'(MAX_WINDOW);
    end else begin
      eff_long = window_len;
    end
    if (avg_window_len == '0) begin
      eff_short = SFILL_W'(1);
    end else if (avg_window_len > SFILL_W'(MAX_SHORT_WINDOW)) begin
      eff_short = SFILL_W'(MAX_SHORT_WINDOW);
    end else begin
      eff_short = avg_window_len;
    end
  end

  // eff_long/10 by reciprocal: (x*1639)>>14 is exact below 2048... checked up to 1024.
  assign lim_prod = 21'(eff_long) * 21'd1639;
  assign lim      = FILL_W'(lim_prod >> 14);

  assign evt_slot = (short_pointer == '0) ? SPTR_W'(eff_short - 7'd1) : short_pointer - 1'b1;
  assign walk_bin = BIN_W'(walk);
  assign ring_slot = SPTR_W'(ridx);

  assign done  = (state == S_IDLE);
  assign q_pop = (state == S_IDLE) && q_valid && !cfg_clear;

  // Histogram memory: one read and one write port.
  logic             hist_we;
  logic [CNT_W-1:0] hist_wd;
  logic [BIN_W-1:0] hist_wa;
  always_ff @(posedge clk) begin
    hist_rd <= histogram[hist_addr];
    if (hist_we) begin
      histogram[hist_wa] <= hist_wd;
    end
  end

  always_comb begin
    hist_addr = cmd.bin;
    if (state == S_SNAP_OLD) begin
      hist_addr = old_bin;
    end else if (state == S_Q_HIST) begin
      hist_addr = walk_bin;
    end
  end

  always_comb begin
    hist_we = 1'b0;
    hist_wa = cmd.bin;
    hist_wd = '0;
    unique case (state)
      S_CLEAR: begin
        hist_we = (sweep < (LPTR_W+1)'(HIST_BINS));
        hist_wa = BIN_W'(sweep);
      end
      S_SNAP_DEC: begin
        hist_we = (fill_count >= eff_long) && (hist_rd != '0);
        hist_wa = old_bin;
        hist_wd = hist_rd - 1'b1;
      end
      S_SNAP_WR: begin
        hist_we = (hist_rd != CNT_MAX);
        hist_wd = hist_rd + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      sweep         <= '0;
      long_pointer  <= '0;
      short_pointer <= '0;
      fill_count    <= '0;
      short_fill    <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_clear) begin
        state <= S_CLEAR;
        sweep <= '0;
        long_pointer  <= '0;
        short_pointer <= '0;
        fill_count    <= '0;
        short_fill    <= '0;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (q_valid) begin
              cmd <= q_head;
              unique case (q_head.action)
                ACT_SNAP:  state <= S_SNAP_RD;
                ACT_SKIP,
                ACT_EMPTY: state <= S_EVT;
                ACT_QUERY: begin
                  state   <= S_Q_HIST;
                  walk    <= (BIN_W+1)'(HIST_BINS - 1);
                  walk_rd <= 1'b0;
                  cum     <= '0;
                  a_found <= 1'b0;
                  seen    <= 1'b0;
                  b_found <= 1'b0;
                  a_bin   <= '0;
                  b_bin   <= '0;
                end
                default: begin
                  state <= S_CLEAR;
                  sweep <= '0;
                  long_pointer  <= '0;
                  short_pointer <= '0;
                  fill_count    <= '0;
                  short_fill    <= '0;
                end
              endcase
            end
          end
          // Clearing pass over every store, with sweep as the address.
          S_CLEAR: begin
            bin_ring[LPTR_W'(sweep)] <= '0;
            if (sweep < (LPTR_W+1)'(MAX_SHORT_WINDOW)) begin
              pend_ring[SPTR_W'(sweep)]  <= '0;
              skip_ring[SPTR_W'(sweep)]  <= '0;
              empty_ring[SPTR_W'(sweep)] <= '0;
            end
            if (sweep == (LPTR_W+1)'(MAX_WINDOW - 1)) begin
              state <= S_IDLE;
            end
            sweep <= sweep + 1'b1;
          end
          S_SNAP_RD: begin
            old_bin <= bin_ring[long_pointer];
            state   <= S_SNAP_OLD;
          end
          S_SNAP_OLD: state <= S_SNAP_DEC;
          S_SNAP_DEC: state <= S_SNAP_INC;
          S_SNAP_INC: state <= S_SNAP_WR;
          S_SNAP_WR: begin
            bin_ring[long_pointer]    <= cmd.bin;
            pend_ring[short_pointer]  <= cmd.pending;
            skip_ring[short_pointer]  <= '0;
            empty_ring[short_pointer] <= '0;
            long_pointer  <= (11'(long_pointer) + 11'd1 >= eff_long) ? '0
                             : long_pointer + 1'b1;
            short_pointer <= (7'(short_pointer) + 7'd1 >= eff_short) ? '0
                             : short_pointer + 1'b1;
            if (fill_count < eff_long) begin
              fill_count <= fill_count + 1'b1;
            end
            if (short_fill < eff_short) begin
              short_fill <= short_fill + 1'b1;
            end
            state <= S_IDLE;
          end
          S_EVT: begin
            evt_rd <= (cmd.action == ACT_SKIP) ? skip_ring[evt_slot] : empty_ring[evt_slot];
            state  <= S_EVT_WR;
          end
          S_EVT_WR: begin
            if (evt_rd != CNT_MAX) begin
              if (cmd.action == ACT_SKIP) begin
                skip_ring[evt_slot] <= evt_rd + 1'b1;
              end else begin
                empty_ring[evt_slot] <= evt_rd + 1'b1;
              end
            end
            state <= S_IDLE;
          end
          // Walk bins top down; hist_rd is registered and holds the bin addressed in the cycle before.
          S_Q_HIST: begin
            walk_rd <= 1'b1;
            if (walk_rd) begin
              if (!a_found && (7'd100 * (cum + 27'(hist_rd)) >= 27'(fill_count))) begin
                a_found <= 1'b1;
                a_bin   <= walk_bin + 1'b1;
              end
              cum <= cum + 27'(hist_rd);
              if (hist_rd != '0 && !b_found) begin
                if (seen) begin
                  b_found <= 1'b1;
                  b_bin   <= walk_bin + 1'b1;
                end
                seen <= 1'b1;
              end
            end
            if (walk == '1) begin
              state   <= S_Q_RING;
              ridx    <= '0;
              ring_rd <= 1'b0;
            end
            walk <= walk - 1'b1;
          end
          S_Q_RING: begin
            pend_rd  <= pend_ring[ring_slot];
            skip_rd  <= skip_ring[ring_slot];
            empty_rd <= empty_ring[ring_slot];
            ring_rd  <= 1'b1;
            if (ring_rd) begin
              if (ridx == (SPTR_W+1)'(1)) begin
                gmin    <= pend_rd;
                skips   <= 22'(skip_rd);
                empties <= 22'(empty_rd);
              end else if ((SFILL_W)'(ridx - 1'b1) < short_fill) begin
                if (pend_rd < gmin) begin
                  gmin <= pend_rd;
                end
                skips   <= skips + 22'(skip_rd);
                empties <= empties + 22'(empty_rd);
              end
            end
            if (ridx == (SPTR_W+1)'(MAX_SHORT_WINDOW)) begin
              state <= S_Q_DONE;
            end
            ridx <= ridx + 1'b1;
          end
          S_Q_DONE: begin
            result_strobe <= 1'b1;
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // Final result assembly from the walk and ring registers.
  logic [12:0] a_val, b_val;
  logic [13:0] a_bin_scaled, b_bin_scaled;
  assign a_bin_scaled = 14'(a_bin) * 14'(BIN_WIDTH);
  assign b_bin_scaled = 14'(b_bin) * 14'(BIN_WIDTH);
  always_comb begin
    if (fill_count > lim) begin
      a_val = a_found ? a_bin_scaled[12:0] : '0;
      b_val = b_found ? b_bin_scaled[12:0] : '0;
    end else begin
      a_val = LOW_FILL_VALUE;
      b_val = LOW_FILL_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_Q_DONE) begin
      result.dev_a              <= a_val;
      result.dev_b              <= b_val;
      result.max_dur            <= (a_val > b_val) ? a_val : b_val;
      result.min_dur            <= (a_val < b_val) ? a_val : b_val;
      result.window_min_pending <= gmin;
      result.skip_total         <= skips;
      result.empty_total        <= empties;
    end
  end

endmodule

// ===== hdl/jitter_histogram_percentile_top.sv =====
// Jitter histogram percentile block. One word at a time; a query walks the bins, then the
// short ring. busy is high after reset and after a register write (clearing pass).
// Reset is synchronous and active high; results cannot be stalled.
module jitter_histogram_percentile_top import jhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_data,
  output logic        result_valid,
  output out_word_t   result_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] window_len;
  logic [6:0]  avg_window_len;
  logic        cfg_we, cfg_clear;
  logic        q_push, q_pop, q_valid, q_nfull, back_done;
  cmd_t        q_in, q_head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len     <= 11'd1024;
      avg_window_len <= 7'd64;
      cfg_clear      <= 1'b0;
    end else begin
      cfg_clear <= 1'b0;
      if (cfg_we) begin
        if (paddr[2] == REG_WINDOW_LEN) begin
          window_len <= pwdata[10:0];
          cfg_clear  <= 1'b1;
        end else if (paddr[2] == REG_AVG_WINDOW_LEN) begin
          avg_window_len <= pwdata[6:0];
          cfg_clear      <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LEN:     prdata = 32'(window_len);
      default:            prdata = 32'(avg_window_len);
    endcase
  end

  // One item in flight: busy until the back end is idle and the queue empty.
  logic in_flight;
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 1'b0;
    end else if (start && !busy) begin
      in_flight <= 1'b1;
    end else if (back_done && !q_valid && !q_push) begin
      in_flight <= 1'b0;
    end
  end
  assign busy = in_flight || !back_done || cfg_clear;

  jhp_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_word(in_data),
    .q_full(q_nfull), .q_push(q_push), .q_cmd(q_in)
  );

  jhp_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_cmd(q_in), .pop(q_pop),
    .not_empty(q_valid), .nearly_full(q_nfull), .head(q_head)
  );

  jhp_back u_back (
    .clk(clk), .rst(rst), .window_len(window_len), .avg_window_len(avg_window_len),
    .cfg_clear(cfg_clear), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .done(back_done), .result_strobe(result_valid), .result(result_data)
  );

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy == $past(busy) || !busy) else $error("result timing");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word not tracked");
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_clear |=> busy) else $error("register write did not start clear");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for jitter_histogram_percentile_top: a clocked driver and
// result monitor, with its own predictor of the histogram and short ring state.
// Depends on jhp_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module testbench;
  import jhp_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_word_t    in_data;
  logic        result_valid;
  out_word_t   result_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  jitter_histogram_percentile_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_data(in_data),
    .result_valid(result_valid), .result_data(result_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicted state of the block.
  int unsigned bin_log [MAX_WINDOW];
  int unsigned hist [HIST_BINS];
  int unsigned pend_log [MAX_SHORT_WINDOW];
  int unsigned skips [MAX_SHORT_WINDOW];
  int unsigned empties [MAX_SHORT_WINDOW];
  int unsigned long_ptr, short_ptr, fill, short_fill;
  int unsigned win_reg, avg_reg;

  in_word_t  pending_words[$];
  out_word_t expected_reports[$];
  int        idle_pct;
  int        errors;
  logic      cfg_busy;

  function automatic int unsigned long_len();
    if (win_reg < 1) return 1;
    if (win_reg > MAX_WINDOW) return MAX_WINDOW;
    return win_reg;
  endfunction

  function automatic int unsigned short_len();
    if (avg_reg < 1) return 1;
    if (avg_reg > MAX_SHORT_WINDOW) return MAX_SHORT_WINDOW;
    return avg_reg;
  endfunction

  function automatic void wipe_state();
    foreach (bin_log[i]) bin_log[i] = 0;
    foreach (hist[i]) hist[i] = 0;
    foreach (pend_log[i]) begin
      pend_log[i] = 0;
      skips[i] = 0;
      empties[i] = 0;
    end
    long_ptr = 0;
    short_ptr = 0;
    fill = 0;
    short_fill = 0;
  endfunction

  // Applies one accepted word to the predicted state, queuing a report for a query.
  function automatic void predict_word(in_word_t w);
    int unsigned nl, ns, lp, sp, b, slot, cum, a, bb, gmin, ssum, esum;
    bit seen;
    out_word_t r;
    nl = long_len();
    ns = short_len();
    case (w.action)
      ACT_SNAP: begin
        lp = long_ptr % nl;
        sp = short_ptr % ns;
        if (fill >= nl && bin_log[lp] < HIST_BINS && hist[bin_log[lp]] > 0)
          hist[bin_log[lp]]--;
        b = 32'(w.duration_ms) / BIN_WIDTH;
        if (b >= HIST_BINS) b = HIST_BINS - 1;
        bin_log[lp] = b;
        if (hist[b] < CNT_MAX) hist[b]++;
        pend_log[sp] = 32'(w.pending_min_ms);
        skips[sp] = 0;
        empties[sp] = 0;
        long_ptr = (lp + 1) % nl;
        short_ptr = (sp + 1) % ns;
        if (fill < nl) fill++;
        if (short_fill < ns) short_fill++;
      end
      ACT_SKIP, ACT_EMPTY: begin
        sp = short_ptr % ns;
        slot = (sp == 0) ? ns - 1 : sp - 1;
        if (w.action == ACT_SKIP) begin
          if (skips[slot] < CNT_MAX) skips[slot]++;
        end else begin
          if (empties[slot] < CNT_MAX) empties[slot]++;
        end
      end
      ACT_QUERY: begin
        a = LOW_FILL_VALUE;
        bb = LOW_FILL_VALUE;
        if (fill > (nl * 10) / 100) begin
          a = 0;
          bb = 0;
          cum = 0;
          for (int i = HIST_BINS - 1; i >= 0; i--) begin
            cum += hist[i];
            if (100 * cum >= fill) begin
              a = i * BIN_WIDTH;
              break;
            end
          end
          seen = 1'b0;
          for (int i = HIST_BINS - 1; i >= 0; i--) begin
            if (hist[i] != 0) begin
              if (seen) begin
                bb = i * BIN_WIDTH;
                break;
              end
              seen = 1'b1;
            end
          end
        end
        gmin = pend_log[0];
        ssum = skips[0];
        esum = empties[0];
        for (int i = 1; i < short_fill; i++) begin
          if (gmin > pend_log[i]) gmin = pend_log[i];
          ssum += skips[i];
          esum += empties[i];
        end
        r.dev_a = 13'(a);
        r.dev_b = 13'(bb);
        r.max_dur = 13'((a > bb) ? a : bb);
        r.min_dur = 13'((a < bb) ? a : bb);
        r.window_min_pending = 16'(gmin);
        r.skip_total = 22'(ssum);
        r.empty_total = 22'(esum);
        expected_reports.push_back(r);
      end
      ACT_CLEAR: wipe_state();
      default: ;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: one word at a time from the pending queue, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_word(in_data);
      void'(pending_words.pop_front());
      if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct && !cfg_busy) begin
        in_data <= pending_words[0];
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_words.size() > 0 && !cfg_busy &&
                 $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      in_data <= pending_words[0];
    end
  end

  // Monitor: every strobed word is checked against the oldest prediction.
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && result_valid) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result word %h", result_data);
        errors++;
      end else begin
        e = expected_reports.pop_front();
        if (result_data.dev_a !== e.dev_a) begin
          $error("dev_a: expected %0d, got %0d", e.dev_a, result_data.dev_a); errors++;
        end
        if (result_data.dev_b !== e.dev_b) begin
          $error("dev_b: expected %0d, got %0d", e.dev_b, result_data.dev_b); errors++;
        end
        if (result_data.max_dur !== e.max_dur) begin
          $error("max_dur: expected %0d, got %0d", e.max_dur, result_data.max_dur);
          errors++;
        end
        if (result_data.min_dur !== e.min_dur) begin
          $error("min_dur: expected %0d, got %0d", e.min_dur, result_data.min_dur);
          errors++;
        end
        if (result_data.window_min_pending !== e.window_min_pending) begin
          $error("window_min_pending: expected %0d, got %0d", e.window_min_pending,
                 result_data.window_min_pending);
          errors++;
        end
        if (result_data.skip_total !== e.skip_total) begin
          $error("skip_total: expected %0d, got %0d", e.skip_total,
                 result_data.skip_total);
          errors++;
        end
        if (result_data.empty_total !== e.empty_total) begin
          $error("empty_total: expected %0d, got %0d", e.empty_total,
                 result_data.empty_total);
          errors++;
        end
      end
    end
  end

  function automatic in_word_t make_word(logic [2:0] act, int unsigned dur, int unsigned pend);
    in_word_t w;
    w.action = act;
    w.duration_ms = 16'(dur);
    w.pending_min_ms = 16'(pend);
    return w;
  endfunction

  // Waits for the driver to drain and every report to arrive.
  task automatic drain();
    while (pending_words.size() > 0 || start || expected_reports.size() > 0)
      @(posedge clk);
  endtask

  // Register write between phases; the write also clears the block.
  task automatic write_reg(int unsigned idx, logic [31:0] value);
    drain();
    cfg_busy = 1'b1;
    // A clear or event may still be in progress with no report pending.
    repeat (1100) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WINDOW_LEN) win_reg = value & 32'h7FF;
    else avg_reg = value & 32'h7F;
    wipe_state();
    @(posedge clk);
    while (busy) @(posedge clk);
    cfg_busy = 1'b0;
  endtask

  function automatic int unsigned rand_duration();
    case ($urandom_range(9))
      0: return $urandom_range(65535);
      1: return $urandom_range(6200, 5900);
      default: return $urandom_range(800);
    endcase
  endfunction

  // Mostly snaps with random events, occasional queries and rare clears and unused codes.
  task automatic random_words(int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 60)
        pending_words.push_back(make_word(ACT_SNAP, rand_duration(), $urandom_range(65535)));
      else if (r < 75)
        pending_words.push_back(make_word(ACT_SKIP, $urandom, $urandom));
      else if (r < 88)
        pending_words.push_back(make_word(ACT_EMPTY, $urandom, $urandom));
      else if (r < 97)
        pending_words.push_back(make_word(ACT_QUERY, $urandom, $urandom));
      else if (r < 98)
        pending_words.push_back(make_word(ACT_CLEAR, $urandom, $urandom));
      else
        pending_words.push_back(make_word(3'($urandom_range(7, 5)), $urandom, $urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cfg_busy = 1'b1;
    idle_pct = 26;
    win_reg = 1024;
    avg_reg = 64;
    wipe_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    cfg_busy = 1'b0;

    // Directed: queries on an empty block, events before any snap, field extremes, unused codes and a clear.
    pending_words.push_back(make_word(ACT_QUERY, 0, 0));
    pending_words.push_back(make_word(ACT_SKIP, 0, 0));
    pending_words.push_back(make_word(ACT_EMPTY, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0));
    pending_words.push_back(make_word(ACT_SNAP, 0, 0));
    pending_words.push_back(make_word(ACT_SNAP, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(make_word(ACT_SNAP, 5999, 16'h5555));
    pending_words.push_back(make_word(ACT_SNAP, 6000, 16'hAAAA));
    pending_words.push_back(make_word(3'd5, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(make_word(3'd6, 0, 0));
    pending_words.push_back(make_word(3'd7, 16'hFFFF, 0));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0));
    pending_words.push_back(make_word(ACT_CLEAR, 0, 0));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0));
    drain();

    // Short windows: low-fill threshold and wrap-around.
    write_reg(REG_WINDOW_LEN, 1);
    write_reg(REG_AVG_WINDOW_LEN, 1);
    pending_words.push_back(make_word(ACT_SNAP, 123, 77));
    for (int i = 0; i < 40; i++) pending_words.push_back(make_word(ACT_SKIP, 0, 0));
    pending_words.push_back(make_word(ACT_SNAP, 4000, 5));
    pending_words.push_back(make_word(ACT_QUERY, 0, 0));
    random_words(120);
    drain();

    write_reg(REG_WINDOW_LEN, 0);
    write_reg(REG_AVG_WINDOW_LEN, 0);
    random_words(60);
    write_reg(REG_WINDOW_LEN, 20);
    write_reg(REG_AVG_WINDOW_LEN, 7);
    random_words(200);
    drain();

    idle_pct = 85;
    write_reg(REG_WINDOW_LEN, 32'h7FF);
    write_reg(REG_AVG_WINDOW_LEN, 32'h7F);
    random_words(200);
    write_reg(REG_WINDOW_LEN, 100);
    write_reg(REG_AVG_WINDOW_LEN, 64);
    random_words(200);
    drain();

    idle_pct = 0;
    write_reg(REG_WINDOW_LEN, 1024);
    write_reg(REG_AVG_WINDOW_LEN, 13);
    random_words(350);
    drain();
    repeat (1500) @(posedge clk);

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
